### hdl/bevvox_pkg.sv
// bevvox_pkg: shared types and constants for the bird's-eye-view voxelizer
// request codes, configuration register indexes, column entry and result records
// no dependencies
`default_nettype none

package bevvox_pkg;

    // default grid dimensions
    localparam int DEF_GRID_X = 256;
    localparam int DEF_GRID_Y = 256;
    localparam int DEF_GRID_Z = 32;

    // field widths fixed by the interface
    localparam int COORD_W  = 24;
    localparam int RECIP_W  = 16;
    localparam int INTEN_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int OCC_W    = 32;
    localparam int CELL_W   = 8;
    localparam int SLICE_W  = 5;
    localparam int CFG_IDX_W = 3;

    // coordinate difference and product widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + RECIP_W + 1;
    localparam int FRAC_SHIFT = 16;

    // reset values of the configuration registers
    localparam logic signed [COORD_W-1:0] RST_MINIMUM = '0;
    localparam logic [RECIP_W-1:0]        RST_RECIP   = 16'd256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request types
    typedef enum logic [1:0] {
        REQ_ADD        = 2'd0,
        REQ_READ       = 2'd1,
        REQ_READ_CLEAR = 2'd2,
        REQ_UNUSED     = 2'd3
    } t_req;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN   = 3'd0,
        CFG_Y_MIN   = 3'd1,
        CFG_Z_MIN   = 3'd2,
        CFG_X_RECIP = 3'd3,
        CFG_Y_RECIP = 3'd4,
        CFG_Z_RECIP = 3'd5
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_IDX,
        S_READ,
        S_WRITE
    } t_state;

    // one column of the map
    typedef struct packed {
        logic [OCC_W-1:0]          occ;
        logic [COUNT_W-1:0]        cnt;
        logic signed [INTEN_W-1:0] inten;
    } t_column;

    // one result record
    typedef struct packed {
        logic                      accepted;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic [SLICE_W-1:0]        cell_z;
        logic [OCC_W-1:0]          occ;
        logic [COUNT_W-1:0]        cnt;
        logic signed [INTEN_W-1:0] inten;
    } t_result;

    // stage enables for the axis units
    typedef struct packed {
        logic diff_en;
        logic mul_en;
    } t_axis_ctl;

endpackage

`default_nettype wire

### hdl/bevvox_axis.sv
// bevvox_axis: one axis of the cell index computation
// registered difference, registered product, range check against the grid size
// depends on bevvox_pkg
`default_nettype none

module bevvox_axis
    import bevvox_pkg::*;
#(
    parameter int GRID = DEF_GRID_X,
    parameter int IW   = 8
) (
    input  wire                              i_clk,
    input  wire t_axis_ctl                   i_ctl,
    input  wire logic signed [COORD_W-1:0]   i_coord,
    input  wire logic signed [COORD_W-1:0]   i_minimum,
    input  wire logic [RECIP_W-1:0]          i_recip,
    output logic                             o_in_range,
    output logic [IW-1:0]                    o_index
);

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-FRAC_SHIFT-1:0] cell_idx;

    // coordinate minus range minimum
    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_diff <= DIFF_W'(i_coord) - DIFF_W'(i_minimum);
        end
    end

    // scale by cells per metre, reciprocal treated as unsigned
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= r_diff * $signed({1'b0, i_recip});
        end
    end

    // floor by dropping the fraction bits, negative products miss
    assign cell_idx   = r_prod[PROD_W-1:FRAC_SHIFT];
    assign o_in_range = !r_prod[PROD_W-1] && (cell_idx < (PROD_W-FRAC_SHIFT)'(GRID));
    assign o_index    = cell_idx[IW-1:0];

endmodule

`default_nettype wire

### hdl/bevvox_colmem.sv
// bevvox_colmem: column store of the map, one synchronous memory
// registered read port, one write port, zeroing sweep after reset
// depends on bevvox_pkg
`default_nettype none

module bevvox_colmem
    import bevvox_pkg::*;
#(
    parameter int DEPTH = DEF_GRID_X * DEF_GRID_Y,
    parameter int AW    = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_rd_en,
    input  wire [AW-1:0]     i_rd_addr,
    output t_column          o_rd_data,
    input  wire              i_wr_en,
    input  wire [AW-1:0]     i_wr_addr,
    input  wire t_column     i_wr_data,
    output logic             o_busy
);

    t_column       r_mem [DEPTH];
    t_column       r_rd_data;
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_column       wr_data;

    // zeroing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // sweep owns the write port while it runs
    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

`default_nettype wire

### hdl/point_cloud_bev_voxelizer_top.sv
// Bird's-eye-view voxelizer: one request in flight; a new one is taken after write back.
// Each request passes through difference, product, index and address,
// memory read, then write back (held while the output is stalled), all through the one column memory port pair.
// Reset clears the control state, loads the default range and scale, and starts
// a zeroing sweep of all GRID_X*GRID_Y columns (65536 by default); requests wait for it.
// Configuration writes are taken in every cycle.
`default_nettype none

module point_cloud_bev_voxelizer_top
    import bevvox_pkg::*;
#(
    parameter int GRID_X = DEF_GRID_X,
    parameter int GRID_Y = DEF_GRID_Y,
    parameter int GRID_Z = DEF_GRID_Z
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [COORD_W-1:0]            i_cfg_data,
    // requests
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [1:0]                    i_req_type,
    input  wire signed [COORD_W-1:0]     i_point_x,
    input  wire signed [COORD_W-1:0]     i_point_y,
    input  wire signed [COORD_W-1:0]     i_point_z,
    input  wire signed [INTEN_W-1:0]     i_point_intensity,
    input  wire [CELL_W-1:0]             i_column_x,
    input  wire [CELL_W-1:0]             i_column_y,
    // results
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_accepted,
    output logic [CELL_W-1:0]            o_cell_x,
    output logic [CELL_W-1:0]            o_cell_y,
    output logic [SLICE_W-1:0]           o_cell_z,
    output logic [OCC_W-1:0]             o_occupancy_mask,
    output logic [COUNT_W-1:0]           o_point_count,
    output logic signed [INTEN_W-1:0]    o_max_intensity
);

    localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ZX_W  = 7;

    // configuration registers
    logic signed [COORD_W-1:0] r_x_min, r_y_min, r_z_min;
    logic [RECIP_W-1:0]        r_x_recip, r_y_recip, r_z_recip;

    // captured request
    t_req                      r_req;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic signed [INTEN_W-1:0] r_inten;
    logic [CELL_W-1:0]         r_colx, r_coly;

    // index stage results
    logic [XW-1:0]             r_cx, n_cx;
    logic [YW-1:0]             r_cy, n_cy;
    logic [ZW-1:0]             r_cz, n_cz;
    logic                      r_hit, n_hit;
    logic [AW-1:0]             r_addr, n_addr;

    t_state                    r_state, n_state;
    t_result                   r_out, n_out;
    logic                      r_out_valid;

    t_axis_ctl                 axis_ctl;
    logic                      x_ok, y_ok, z_ok;
    logic [XW-1:0]             x_idx;
    logic [YW-1:0]             y_idx;
    logic [ZW-1:0]             z_idx;
    logic [31:0]               sel_x, sel_y;

    logic                      mem_busy;
    logic                      mem_rd_en;
    t_column                   mem_rd_data;
    logic                      mem_wr_en;
    t_column                   mem_wr_data;

    logic                      in_take;
    logic                      out_free;
    logic [ZX_W-1:0]           cz_ext;
    logic [OCC_W-1:0]          slice_bit;
    t_column                   upd;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min   <= RST_MINIMUM;
            r_y_min   <= RST_MINIMUM;
            r_z_min   <= RST_MINIMUM;
            r_x_recip <= RST_RECIP;
            r_y_recip <= RST_RECIP;
            r_z_recip <= RST_RECIP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_MIN:   r_x_min   <= i_cfg_data;
                CFG_Y_MIN:   r_y_min   <= i_cfg_data;
                CFG_Z_MIN:   r_z_min   <= i_cfg_data;
                CFG_X_RECIP: r_x_recip <= i_cfg_data[RECIP_W-1:0];
                CFG_Y_RECIP: r_y_recip <= i_cfg_data[RECIP_W-1:0];
                CFG_Z_RECIP: r_z_recip <= i_cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || mem_busy;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req   <= t_req'(i_req_type);
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_pz    <= i_point_z;
            r_inten <= i_point_intensity;
            r_colx  <= i_column_x;
            r_coly  <= i_column_y;
        end
    end

    // per-axis index units
    assign axis_ctl.diff_en = (r_state == S_DIFF);
    assign axis_ctl.mul_en  = (r_state == S_MUL);

    bevvox_axis #(.GRID(GRID_X), .IW(XW)) u_axis_x (
        .i_clk      (i_clk),
        .i_ctl      (axis_ctl),
        .i_coord    (r_px),
        .i_minimum  (r_x_min),
        .i_recip    (r_x_recip),
        .o_in_range (x_ok),
        .o_index    (x_idx)
    );

    bevvox_axis #(.GRID(GRID_Y), .IW(YW)) u_axis_y (
        .i_clk      (i_clk),
        .i_ctl      (axis_ctl),
        .i_coord    (r_py),
        .i_minimum  (r_y_min),
        .i_recip    (r_y_recip),
        .o_in_range (y_ok),
        .o_index    (y_idx)
    );

    bevvox_axis #(.GRID(GRID_Z), .IW(ZW)) u_axis_z (
        .i_clk      (i_clk),
        .i_ctl      (axis_ctl),
        .i_coord    (r_pz),
        .i_minimum  (r_z_min),
        .i_recip    (r_z_recip),
        .o_in_range (z_ok),
        .o_index    (z_idx)
    );

    // hit test and column address
    always_comb begin
        n_cx = x_idx;
        n_cy = y_idx;
        n_cz = z_idx;
        if (r_req == REQ_ADD) begin
            n_hit = x_ok && y_ok && z_ok;
            sel_x = 32'(x_idx);
            sel_y = 32'(y_idx);
        end else begin
            n_hit = (r_req != REQ_UNUSED)
                 && (32'(r_colx) < 32'(GRID_X))
                 && (32'(r_coly) < 32'(GRID_Y));
            sel_x = 32'(r_colx);
            sel_y = 32'(r_coly);
        end
        n_addr = AW'(sel_y * 32'(GRID_X) + sel_x);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDX) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_cz   <= n_cz;
            r_hit  <= n_hit;
            r_addr <= n_addr;
        end
    end

    // column memory
    assign mem_rd_en = (r_state == S_READ);

    bevvox_colmem #(.DEPTH(DEPTH), .AW(AW)) u_colmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wr_data),
        .o_busy    (mem_busy)
    );

    // point update of the column read back
    assign cz_ext    = ZX_W'(r_cz);
    assign slice_bit = (cz_ext < ZX_W'(OCC_W)) ? (OCC_W'(1) << cz_ext[SLICE_W-1:0]) : '0;

    always_comb begin
        upd.occ   = mem_rd_data.occ | slice_bit;
        upd.cnt   = (mem_rd_data.cnt == COUNT_MAX) ? mem_rd_data.cnt
                                                   : mem_rd_data.cnt + 1'b1;
        upd.inten = ($signed(r_inten) > $signed(mem_rd_data.inten)) ? r_inten
                                                                     : mem_rd_data.inten;
    end

    // write back and result
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out       = '0;
        mem_wr_en   = 1'b0;
        mem_wr_data = '0;
        unique case (r_req)
            REQ_ADD: begin
                if (r_hit) begin
                    mem_wr_en      = 1'b1;
                    mem_wr_data    = upd;
                    n_out.accepted = 1'b1;
                    n_out.cell_x   = CELL_W'(r_cx);
                    n_out.cell_y   = CELL_W'(r_cy);
                    n_out.cell_z   = cz_ext[SLICE_W-1:0];
                    n_out.occ      = upd.occ;
                    n_out.cnt      = upd.cnt;
                    n_out.inten    = upd.inten;
                end
            end
            REQ_READ, REQ_READ_CLEAR: begin
                n_out.cell_x = r_colx;
                n_out.cell_y = r_coly;
                if (r_hit) begin
                    mem_wr_en      = (r_req == REQ_READ_CLEAR);
                    n_out.accepted = 1'b1;
                    n_out.occ      = mem_rd_data.occ;
                    n_out.cnt      = mem_rd_data.cnt;
                    n_out.inten    = mem_rd_data.inten;
                end
            end
            REQ_UNUSED: ;
        endcase
        if (!(r_state == S_WRITE && out_free)) begin
            mem_wr_en = 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_IDX;
            S_IDX:   n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: if (out_free) n_state = S_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_WRITE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out.accepted;
    assign o_cell_x         = r_out.cell_x;
    assign o_cell_y         = r_out.cell_y;
    assign o_cell_z         = r_out.cell_z;
    assign o_occupancy_mask = r_out.occ;
    assign o_point_count    = r_out.cnt;
    assign o_max_intensity  = r_out.inten;

endmodule

`default_nettype wire

### hdl/bevvox_checker.sv
// bevvox_checker: port-level checks of the voxelizer over time
// bound to point_cloud_bev_voxelizer_top; depends on bevvox_pkg
`default_nettype none

module bevvox_checker
    import bevvox_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          o_in_stall,
    input  wire                          o_out_valid,
    input  wire                          i_out_stall,
    input  wire                          o_accepted,
    input  wire [SLICE_W-1:0]            o_cell_z,
    input  wire [OCC_W-1:0]              o_occupancy_mask,
    input  wire [COUNT_W-1:0]            o_point_count,
    input  wire signed [INTEN_W-1:0]     o_max_intensity
);

    // map is being swept right after reset, no request may enter
    a_stall_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("request port open during zeroing sweep");

    // one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // a held result stays valid and keeps its accepted flag, occupancy mask and point count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_accepted)
            && $stable(o_occupancy_mask) && $stable(o_point_count)))
        else $error("stalled result changed");

    // rejected requests carry an empty column
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_cell_z == '0 && o_occupancy_mask == '0
            && o_point_count == '0 && o_max_intensity == '0))
        else $error("rejected request returned column data");

    // occupied slices imply points counted, and the maximum never drops below zero
    a_column_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_occupancy_mask == '0 || o_point_count != '0)
            && !o_max_intensity[INTEN_W-1]))
        else $error("inconsistent column contents");

endmodule

bind point_cloud_bev_voxelizer_top bevvox_checker u_bevvox_checker (.*);

`default_nettype wire
